// ===== rtl/dtsi_pkg.sv =====
`timescale 1ns / 1ps

package dtsi_pkg;

    // Scan phases of one string
    typedef enum logic [2:0] {
        PH_LEAD   = 3'd0,
        PH_SIGNED = 3'd1,
        PH_DIGITS = 3'd2,
        PH_TRAIL  = 3'd3,
        PH_FAILED = 3'd4
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Configuration register indexes
    localparam logic CFG_WIDTH_SELECT  = 1'b0;
    localparam logic CFG_REQUIRE_DIGIT = 1'b1;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam int NUM_RADIX    = 10;
    localparam int VALUE_W      = 32;
    localparam int ACC_X_W      = VALUE_W + 5;

    typedef struct packed {
        logic width_select;   // 0: signed 16-bit, 1: signed 32-bit
        logic require_digit;  // strict mode
    } cfg_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
    } result_t;

endpackage

// ===== rtl/decimal_text_to_signed_int.sv =====
`timescale 1ns / 1ps
// Decimal text to signed integer parser.
// Input channel (in_valid / in_stall): one character word per cycle, with
// end_of_text high on the terminator word that closes the string; its
// char_code is ignored. A word is taken when in_valid is high and in_stall
// is low.
// Output channel (out_valid / out_stall): one word per string, produced by
// the terminator, carrying value and status (0 ok, 1 syntax, 2 range).
// value is 0 whenever status is not ok.
// A taken terminator word passes the input register, then the result
// register, where its result can be read. Throughput is one word per cycle
// while in_stall is low; the accumulate step (acc * 10 - digit) is
// combinational.
// Stall: character words keep flowing while a result waits; only a second
// terminator backs up behind an unread result, which raises in_stall.
// Config (cfg_valid / cfg_ready, always ready): index 0 width_select,
// index 1 require_digit. Write only while the parser is idle.
// Reset: parse state cleared, no word pending, 32-bit lax mode selected.

module decimal_text_to_signed_int
    import dtsi_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                char_code,
    input  logic                      end_of_text,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] value,
    output logic [1:0]                status,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic                      cfg_data
);

    // input register
    logic       in_vld_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;

    // result register
    logic       out_vld_reg;
    result_t    out_res_reg;

    cfg_t       cfg_reg;
    result_t    step_res;
    logic       out_free;
    logic       proc_go;
    logic       in_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_select  <= 1'b1;
            cfg_reg.require_digit <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_WIDTH_SELECT:  cfg_reg.width_select  <= cfg_data;
                CFG_REQUIRE_DIGIT: cfg_reg.require_digit <= cfg_data;
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Character words always drain; a terminator needs room in the result reg
    assign out_free = !out_vld_reg || !out_stall;
    assign proc_go  = in_vld_reg && (!in_eot_reg || out_free);
    assign in_stall = in_vld_reg && !proc_go;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (in_take)
            in_vld_reg <= 1'b1;
        else if (proc_go)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= char_code;
            in_eot_reg  <= end_of_text;
        end
    end

    dtsi_parse u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .go          (proc_go),
        .char_code   (in_char_reg),
        .end_of_text (in_eot_reg),
        .cfg         (cfg_reg),
        .result      (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (proc_go && in_eot_reg)
            out_vld_reg <= 1'b1;
        else if (!out_stall)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_go && in_eot_reg)
            out_res_reg <= step_res;
    end

    assign out_valid = out_vld_reg;
    assign value     = out_res_reg.value;
    assign status    = out_res_reg.status;

    // A stall can only come from a terminator waiting on an unread result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && in_eot_reg && out_vld_reg && out_stall))
        else $error("input stalled without a blocked terminator");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == ST_OK || status == ST_SYNTAX || status == ST_RANGE))
        else $error("undefined status code");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (value == '0))
        else $error("nonzero value on error");

    // A result never gets overwritten while the receiver holds it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && out_stall) |-> !(proc_go && in_eot_reg))
        else $error("result overwritten while stalled");

endmodule

// ===== rtl/dtsi_parse.sv =====
`timescale 1ns / 1ps

module dtsi_parse
    import dtsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       go,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    input  cfg_t       cfg,
    output result_t    result
);

    phase_t                    phase_reg, phase_next;
    logic                      neg_reg, neg_next;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    status_t                   err_reg, err_next;

    logic                      is_blank;
    logic                      is_digit;
    logic [3:0]                digit;
    logic signed [ACC_X_W-1:0] acc_ext;
    logic signed [ACC_X_W-1:0] acc_x;
    logic signed [ACC_X_W-1:0] wmin_x;
    logic signed [VALUE_W-1:0] wmin;
    logic                      digit_ovf;

    assign is_blank = (char_code == CHAR_SPACE) ||
                      ((char_code >= CHAR_TAB) && (char_code <= CHAR_CR));
    assign is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
    assign digit    = 4'(char_code - CHAR_ZERO);

    // acc * 10 - digit, as shifts and adds
    assign acc_ext = ACC_X_W'(acc_reg);
    assign acc_x   = (acc_ext <<< 3) + (acc_ext <<< 1) - ACC_X_W'({1'b0, digit});

    assign wmin      = cfg.width_select ? {1'b1, {(VALUE_W-1){1'b0}}}
                                        : -(VALUE_W'(32'sd32768));
    assign wmin_x    = ACC_X_W'(wmin);
    assign digit_ovf = acc_x < wmin_x;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        err_next   = err_reg;
        result.value  = '0;
        result.status = err_reg;

        if (end_of_text)
        begin
            if (phase_reg != PH_FAILED)
            begin
                if (((phase_reg == PH_LEAD) || (phase_reg == PH_SIGNED)) &&
                    cfg.require_digit)
                    result.status = ST_SYNTAX;
                else if (acc_reg < wmin)
                    result.status = ST_RANGE;
                else if (!neg_reg && (acc_reg == wmin))
                    result.status = ST_RANGE;
                else
                begin
                    result.status = ST_OK;
                    result.value  = neg_reg ? acc_reg : -acc_reg;
                end
            end
            phase_next = PH_LEAD;
            neg_next   = 1'b0;
            acc_next   = '0;
            err_next   = ST_OK;
        end
        else
        begin
            unique case (phase_reg)
                PH_LEAD, PH_SIGNED, PH_DIGITS:
                begin
                    if (is_digit)
                    begin
                        if (digit_ovf)
                        begin
                            err_next   = ST_RANGE;
                            phase_next = PH_FAILED;
                        end
                        else
                        begin
                            acc_next   = VALUE_W'(acc_x);
                            phase_next = PH_DIGITS;
                        end
                    end
                    else if (is_blank)
                    begin
                        if (phase_reg == PH_DIGITS)
                            phase_next = PH_TRAIL;
                        else if (phase_reg == PH_SIGNED && cfg.width_select)
                        begin
                            if (cfg.require_digit)
                            begin
                                err_next   = ST_SYNTAX;
                                phase_next = PH_FAILED;
                            end
                            else
                                phase_next = PH_TRAIL;
                        end
                    end
                    else if (phase_reg == PH_LEAD && char_code == CHAR_MINUS)
                    begin
                        neg_next   = 1'b1;
                        phase_next = PH_SIGNED;
                    end
                    else if (phase_reg == PH_LEAD && char_code == CHAR_PLUS)
                        phase_next = PH_SIGNED;
                    else
                    begin
                        err_next   = ST_SYNTAX;
                        phase_next = PH_FAILED;
                    end
                end
                PH_TRAIL:
                begin
                    if (!is_blank)
                    begin
                        err_next   = ST_SYNTAX;
                        phase_next = PH_FAILED;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            err_reg   <= ST_OK;
        end
        else if (go)
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            acc_reg   <= acc_next;
            err_reg   <= err_next;
        end
    end

endmodule
